/* rtl/assert_macros.svh */
// Assertion shorthands shared by the checker files.
// All of them sample on clk_i and are switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CPT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("property failed");

`define CPT_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

/* rtl/cpt_pkg.sv */
package cpt_pkg;

  localparam int CoordWidth = 32;

  typedef enum logic [2:0] {
    RG_VERT_A   = 3'd0,
    RG_VERT_B   = 3'd1,
    RG_VERT_C   = 3'd2,
    RG_EDGE_AB  = 3'd3,
    RG_EDGE_BC  = 3'd4,
    RG_EDGE_CA  = 3'd5,
    RG_INTERIOR = 3'd6
  } region_e;

  // Difference vectors: 0 p-a, 1 p-b, 2 p-c, 3 b-a, 4 c-a, 5 c-b.
  // Dot products: snom, sdenom, tnom, tdenom, unom, udenom.
  localparam int DotU [6] = '{0, 1, 0, 2, 1, 2};
  localparam int DotV [6] = '{3, 3, 4, 4, 5, 5};
  localparam bit DotNeg [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  // Cross products: normal ab x ac, then (p-a)x(p-b), (p-b)x(p-c), (p-c)x(p-a).
  localparam int CrsU [4] = '{3, 0, 1, 2};
  localparam int CrsV [4] = '{4, 1, 2, 0};

endpackage

/* rtl/closest_point_on_triangle.sv */
// Channel   | Dir | Payload
// s_axis    | in  | tdata: point x,y,z, vertex a x,y,z, vertex b x,y,z, vertex c x,y,z
// m_axis    | out | tdata: near x,y,z; tuser: region, degenerate
//
// One transaction is accepted per cycle unless an output stall has filled the
// pipeline; most of its stages lie in the restoring divider, which resolves
// one quotient bit per stage for all three coordinates.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stall on the output holds the filled stages, while empty stages keep
// taking new transactions until the pipeline is full.
module closest_point_on_triangle #(
  parameter int COORD_WIDTH = cpt_pkg::CoordWidth
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // point_x, point_y, point_z, vert_a_x .. vert_a_z, vert_b_x .. vert_b_z,
  // vert_c_x .. vert_c_z, then zero padding
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // near_x, near_y, near_z, then zero padding
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  // region, degenerate
  output logic [3:0]                                 m_axis_tuser
);
  import cpt_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int DW     = W + 1;
  localparam int PW     = 2*DW + 2;
  localparam int CW     = 2*DW + 1;
  localparam int H      = W + 2;
  localparam int PPW    = 2*H + 2;
  localparam int PRW    = 2*CW;
  localparam int VW     = PRW + 2;
  localparam int DNW    = VW + 2;
  localparam int NPW    = W + H + 1;
  localparam int CSW    = NPW + 2;
  localparam int NUMW   = W + VW + 2;
  localparam int RW     = NUMW + 1;
  localparam int QW     = W + 1;
  localparam int OUT_DW = ((3*W+7)/8)*8;

  localparam int ST_DIF = 0;
  localparam int ST_MUL = 1;
  localparam int ST_SUM = 2;
  localparam int ST_PP  = 3;
  localparam int ST_PRD = 4;
  localparam int ST_VOL = 5;
  localparam int ST_WGT = 6;
  localparam int ST_DEN = 7;
  localparam int ST_NPP = 8;
  localparam int ST_CSM = 9;
  localparam int ST_NUM = 10;
  localparam int ST_ABS = 11;
  localparam int ST_OVF = 12;
  localparam int ST_OUT = ST_OVF + W + 2;
  localparam int NST    = ST_OUT + 1;

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic [NST:0]   en;
  logic [NST-1:0] vld_q;

  assign en[NST] = m_axis_tready;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];

  // Differences and vertex carry
  logic signed [W-1:0]  in_c [12];
  logic signed [DW-1:0] df_q [6][3];
  logic signed [W-1:0]  crd_q [ST_DEN+1][9];

  for (genvar f = 0; f < 12; f++) begin : g_in
    assign in_c[f] = s_axis_tdata[f*W +: W];
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIF]) begin
      for (int i = 0; i < 3; i++) begin
        df_q[0][i] <= DW'(in_c[i])   - DW'(in_c[3+i]);
        df_q[1][i] <= DW'(in_c[i])   - DW'(in_c[6+i]);
        df_q[2][i] <= DW'(in_c[i])   - DW'(in_c[9+i]);
        df_q[3][i] <= DW'(in_c[6+i]) - DW'(in_c[3+i]);
        df_q[4][i] <= DW'(in_c[9+i]) - DW'(in_c[3+i]);
        df_q[5][i] <= DW'(in_c[9+i]) - DW'(in_c[6+i]);
      end
      for (int j = 0; j < 9; j++) crd_q[0][j] <= in_c[3+j];
    end
    for (int k = 1; k <= ST_DEN; k++) begin
      if (en[k]) crd_q[k] <= crd_q[k-1];
    end
  end

  // Products of differences
  logic signed [2*DW-1:0] dp_q [6][3];
  logic signed [2*DW-1:0] cp_q [4][3][2];

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      for (int d = 0; d < 6; d++) begin
        for (int j = 0; j < 3; j++) dp_q[d][j] <= df_q[DotU[d]][j] * df_q[DotV[d]][j];
      end
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 3; i++) begin
          cp_q[c][i][0] <= df_q[CrsU[c]][(i+1)%3] * df_q[CrsV[c]][(i+2)%3];
          cp_q[c][i][1] <= df_q[CrsU[c]][(i+2)%3] * df_q[CrsV[c]][(i+1)%3];
        end
      end
    end
  end

  // Dot sums and cross components
  logic signed [PW-1:0] dsum [6];
  logic signed [PW-1:0] dt_q [4][6];
  logic signed [CW-1:0] cr_q [4][3];

  for (genvar d = 0; d < 6; d++) begin : g_dsum
    assign dsum[d] = PW'(dp_q[d][0]) + PW'(dp_q[d][1]) + PW'(dp_q[d][2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      for (int d = 0; d < 6; d++) dt_q[0][d] <= DotNeg[d] ? -dsum[d] : dsum[d];
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 3; i++) cr_q[c][i] <= CW'(cp_q[c][i][0]) - CW'(cp_q[c][i][1]);
      end
    end
    for (int k = ST_PP; k <= ST_VOL; k++) begin
      if (en[k]) dt_q[k-ST_SUM] <= dt_q[k-ST_SUM-1];
    end
  end

  // Triple products n . (u x v), split into partial products
  logic signed [H:0]     cl [4][3];
  logic signed [W:0]     ch [4][3];
  logic signed [PPW-1:0] pp_q [3][3][4];
  logic signed [PRW-1:0] pr_q [3][3];
  logic signed [VW-1:0]  vl_q [3];

  for (genvar c = 0; c < 4; c++) begin : g_split
    for (genvar i = 0; i < 3; i++) begin : g_comp
      assign cl[c][i] = $signed({1'b0, cr_q[c][i][H-1:0]});
      assign ch[c][i] = cr_q[c][i][CW-1:H];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_PP]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pp_q[k][i][0] <= cl[0][i] * cl[k+1][i];
          pp_q[k][i][1] <= cl[0][i] * ch[k+1][i];
          pp_q[k][i][2] <= ch[0][i] * cl[k+1][i];
          pp_q[k][i][3] <= ch[0][i] * ch[k+1][i];
        end
      end
    end
    if (en[ST_PRD]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pr_q[k][i] <= PRW'(pp_q[k][i][0])
                      + ((PRW'(pp_q[k][i][1]) + PRW'(pp_q[k][i][2])) <<< H)
                      + (PRW'(pp_q[k][i][3]) <<< (2*H));
        end
      end
    end
    if (en[ST_VOL]) begin
      for (int k = 0; k < 3; k++) begin
        vl_q[k] <= VW'(pr_q[k][0]) + VW'(pr_q[k][1]) + VW'(pr_q[k][2]);
      end
    end
  end

  // Region tests, in the order vertex a, b, c, then edge ab, bc, ca
  logic signed [VW-1:0] sn, sd, tn, td, un, ud, vc, va, vb;
  logic signed [VW-1:0] w_sel [3];
  region_e              r_sel;

  always_comb begin
    sn = VW'(dt_q[ST_VOL-ST_SUM][0]);
    sd = VW'(dt_q[ST_VOL-ST_SUM][1]);
    tn = VW'(dt_q[ST_VOL-ST_SUM][2]);
    td = VW'(dt_q[ST_VOL-ST_SUM][3]);
    un = VW'(dt_q[ST_VOL-ST_SUM][4]);
    ud = VW'(dt_q[ST_VOL-ST_SUM][5]);
    vc = vl_q[0];
    va = vl_q[1];
    vb = vl_q[2];
    w_sel[0] = '0;
    w_sel[1] = '0;
    w_sel[2] = '0;
    if (sn[VW-1] && tn[VW-1]) begin
      w_sel[0] = VW'(1);
      r_sel    = RG_VERT_A;
    end else if (sd[VW-1] && (un[VW-1] || un == '0)) begin
      w_sel[1] = VW'(1);
      r_sel    = RG_VERT_B;
    end else if (td[VW-1] && (ud[VW-1] || ud == '0)) begin
      w_sel[2] = VW'(1);
      r_sel    = RG_VERT_C;
    end else if ((vc[VW-1] || vc == '0) && !sn[VW-1] && !sd[VW-1]) begin
      w_sel[0] = sd;
      w_sel[1] = sn;
      r_sel    = RG_EDGE_AB;
    end else if ((va[VW-1] || va == '0) && !un[VW-1] && !ud[VW-1]) begin
      w_sel[1] = ud;
      w_sel[2] = un;
      r_sel    = RG_EDGE_BC;
    end else if ((vb[VW-1] || vb == '0) && !tn[VW-1] && !td[VW-1]) begin
      w_sel[0] = td;
      w_sel[2] = tn;
      r_sel    = RG_EDGE_CA;
    end else begin
      w_sel[0] = va;
      w_sel[1] = vb;
      w_sel[2] = vc;
      r_sel    = RG_INTERIOR;
    end
  end

  logic signed [VW-1:0]  wt_q [2][3];
  region_e               rgp_q [ST_ABS-ST_WGT+1];
  logic signed [DNW-1:0] dn_q [ST_ABS-ST_DEN];
  logic                  dg_q [ST_ABS-ST_NPP+1];

  // A zero divisor falls back to vertex a with unit weight.
  logic                 zd;
  logic signed [VW-1:0] w_fin [3];
  logic signed [H:0]    chk [3][4];

  assign zd = (dn_q[0] == '0);
  for (genvar t = 0; t < 3; t++) begin : g_wfin
    assign w_fin[t] = zd ? ((t == 0) ? VW'(1) : '0) : wt_q[1][t];
    for (genvar j = 0; j < 3; j++) begin : g_lo
      assign chk[t][j] = $signed({1'b0, w_fin[t][j*H +: H]});
    end
    assign chk[t][3] = (H+1)'($signed(w_fin[t][3*H +: H]));
  end

  logic signed [NPW-1:0]  np_q [3][3][4];
  logic signed [CSW-1:0]  cs_q [3][4];
  logic signed [NUMW-1:0] nm_q [3];

  always_ff @(posedge clk_i) begin
    if (en[ST_WGT]) begin
      wt_q[0]  <= w_sel;
      rgp_q[0] <= r_sel;
    end
    if (en[ST_DEN]) begin
      wt_q[1]  <= wt_q[0];
      dn_q[0]  <= DNW'(wt_q[0][0]) + DNW'(wt_q[0][1]) + DNW'(wt_q[0][2]);
    end
    for (int k = ST_DEN; k <= ST_ABS; k++) begin
      if (en[k]) begin
        rgp_q[k-ST_WGT] <= (k == ST_NPP && zd) ? RG_VERT_A
                                                : rgp_q[k-ST_WGT-1];
      end
    end
    if (en[ST_NPP]) begin
      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 3; t++) begin
          for (int j = 0; j < 4; j++) np_q[i][t][j] <= crd_q[ST_DEN][3*t+i] * chk[t][j];
        end
      end
      dn_q[1] <= zd ? DNW'(1) : dn_q[0];
      dg_q[0] <= zd;
    end
    for (int k = ST_CSM; k < ST_ABS; k++) begin
      if (en[k]) dn_q[k-ST_DEN] <= dn_q[k-ST_DEN-1];
    end
    for (int k = ST_CSM; k <= ST_ABS; k++) begin
      if (en[k]) dg_q[k-ST_NPP] <= dg_q[k-ST_NPP-1];
    end
    if (en[ST_CSM]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          cs_q[i][j] <= CSW'(np_q[i][0][j]) + CSW'(np_q[i][1][j]) + CSW'(np_q[i][2][j]);
        end
      end
    end
    if (en[ST_NUM]) begin
      for (int i = 0; i < 3; i++) begin
        nm_q[i] <= NUMW'(cs_q[i][0])
                 + (NUMW'(cs_q[i][1]) <<< H)
                 + (NUMW'(cs_q[i][2]) <<< (2*H))
                 + (NUMW'(cs_q[i][3]) <<< (3*H));
      end
    end
  end

  // Magnitudes and quotient sign
  logic [NUMW-1:0] mg_q [3];
  logic            ng_q [3];
  logic [DNW-1:0]  mdn_q;
  logic signed [DNW-1:0] dn_last;

  assign dn_last = dn_q[ST_ABS-ST_DEN-1];

  always_ff @(posedge clk_i) begin
    if (en[ST_ABS]) begin
      for (int i = 0; i < 3; i++) begin
        mg_q[i] <= nm_q[i][NUMW-1] ? -nm_q[i] : nm_q[i];
        ng_q[i] <= nm_q[i][NUMW-1] ^ dn_last[DNW-1];
      end
      mdn_q <= dn_last[DNW-1] ? -dn_last : dn_last;
    end
  end

  // Restoring division. Entry 0 flags quotients of 2**QW or more; entry m
  // holds the remainder after quotient bit QW-m has been resolved.
  logic [RW-1:0]  dr_q  [W+2][3];
  logic [QW-1:0]  qt_q  [W+2][3];
  logic           ov_q  [W+2][3];
  logic           ngd_q [W+2][3];
  logic [DNW-1:0] md_q  [W+2];
  region_e        rgd_q [W+2];
  logic           dgd_q [W+2];

  always_ff @(posedge clk_i) begin
    if (en[ST_OVF]) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i]  <= RW'(mg_q[i]);
        qt_q[0][i]  <= '0;
        ov_q[0][i]  <= RW'(mg_q[i]) >= (RW'(mdn_q) << QW);
        ngd_q[0][i] <= ng_q[i];
      end
      md_q[0]  <= mdn_q;
      rgd_q[0] <= rgp_q[ST_ABS-ST_WGT];
      dgd_q[0] <= dg_q[ST_ABS-ST_NPP];
    end
  end

  for (genvar m = 1; m <= W + 1; m++) begin : g_div
    logic [RW-1:0] trial;
    logic [2:0]    ge;

    assign trial = RW'(md_q[m-1]) << (QW - m);
    for (genvar i = 0; i < 3; i++) begin : g_ge
      assign ge[i] = dr_q[m-1][i] >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_OVF+m]) begin
        for (int i = 0; i < 3; i++) begin
          dr_q[m][i]  <= ge[i] ? dr_q[m-1][i] - trial : dr_q[m-1][i];
          qt_q[m][i]  <= qt_q[m-1][i] | (ge[i] ? (QW'(1) << (QW - m)) : '0);
          ov_q[m][i]  <= ov_q[m-1][i];
          ngd_q[m][i] <= ngd_q[m-1][i];
        end
        md_q[m]  <= md_q[m-1];
        rgd_q[m] <= rgd_q[m-1];
        dgd_q[m] <= dgd_q[m-1];
      end
    end
  end

  // Sign, truncation toward zero and saturation
  logic [W-1:0] res [3];
  logic [W-1:0] out_q [3];
  region_e      org_q;
  logic         odg_q;

  for (genvar i = 0; i < 3; i++) begin : g_res
    logic [QW-1:0] q;
    assign q = qt_q[W+1][i];
    always_comb begin
      if (ngd_q[W+1][i]) begin
        if (ov_q[W+1][i] || q > (QW'(1) << (W - 1))) res[i] = {1'b1, {(W-1){1'b0}}};
        else res[i] = -q[W-1:0];
      end else begin
        if (ov_q[W+1][i] || q > QW'({(W-1){1'b1}})) res[i] = {1'b0, {(W-1){1'b1}}};
        else res[i] = q[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q <= res;
      org_q <= rgd_q[W+1];
      odg_q <= dgd_q[W+1];
    end
  end

  assign m_axis_tvalid = vld_q[ST_OUT];
  assign m_axis_tdata  = OUT_DW'({out_q[2], out_q[1], out_q[0]});
  assign m_axis_tuser  = {odg_q, org_q};

endmodule

/* rtl/cpt_chk.sv */
`include "assert_macros.svh"

module cpt_chk #(
  parameter int COORD_WIDTH = cpt_pkg::CoordWidth
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  // near_x, near_y, near_z, then zero padding
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  // region, degenerate
  input logic [3:0]                          m_axis_tuser
);
  import cpt_pkg::*;

  // With the output free, every stage can move, so the input must be open.
  `CPT_ASSERT(a_ready_when_free, !m_axis_tvalid || m_axis_tready |-> s_axis_tready)

  `CPT_ASSERT(a_out_hold,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  `CPT_ASSERT_MSG(a_degen_region,
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == RG_VERT_A,
    "degenerate result must report vertex a")

endmodule

bind closest_point_on_triangle cpt_chk #(.COORD_WIDTH(COORD_WIDTH)) u_cpt_chk (.*);
